>>> rtl/stepper_extremum_indexer_assert.svh
// Assertion macros used by the RTL file stepper_extremum_indexer.sv.
`ifndef STEPPER_EXTREMUM_INDEXER_ASSERT_SVH
`define STEPPER_EXTREMUM_INDEXER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SEI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SEI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sei_pkg.sv
package sei_pkg;

  // Field and state widths
  localparam int SAMPLE_W   = 10;
  localparam int COEF_W     = 8;
  localparam int VALUE_W    = 12;
  localparam int DELTA_W    = 12;
  localparam int COUNT_W    = 8;
  localparam int SUM_W      = 13;
  localparam int PHASE_W    = 3;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Priming reads before direction finding
  localparam int PRIME_READS_DEF = 5;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRIME  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DIR    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_MAX    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_MIN    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_OFFSET = 3'd5;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_IDLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STEP = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_DONE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_NEWEST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OLDEST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_STEPS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_STEPS    = 3'd5;

  // Register reset values
  localparam logic [COEF_W-1:0]  COEF_NEWEST_RST     = 8'd179;
  localparam logic [COEF_W-1:0]  COEF_MIDDLE_RST     = 8'd77;
  localparam logic [COEF_W-1:0]  COEF_OLDEST_RST     = 8'd102;
  localparam logic [DELTA_W-1:0] DELTA_RST           = 12'd50;
  localparam logic [COUNT_W-1:0] DIRECTION_STEPS_RST = 8'd15;
  localparam logic [COUNT_W-1:0] OFFSET_STEPS_RST    = 8'd0;

  // Filter weights, Q0.8
  typedef struct packed {
    logic [COEF_W-1:0] newest;
    logic [COEF_W-1:0] middle;
    logic [COEF_W-1:0] oldest;
  } sei_coef_t;

endpackage

>>> rtl/stepper_extremum_indexer.sv
// Stepper extremum indexer: each input word carries one 10-bit sensor sample
// and yields exactly one result word, the action for the motor (idle, read
// again, step then read, done) and the filter output for that word. The
// filter is a three-tap FIR over the previously stored samples with Q0.8
// weights. A start request while idle begins a move: priming reads, stepped
// reads that decide the direction, a maximum or minimum search ending when the
// value departs by delta, then offset steps. One word is accepted every cycle
// while the output register is empty or being emptied, with its result there
// on the next cycle. The user must write configuration through cfg_we/
// cfg_index/cfg_data only while no move is in flight; the block does not enforce it.
module stepper_extremum_indexer #(
  parameter int PRIME_READS = sei_pkg::PRIME_READS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              start_req,
  input  logic [sei_pkg::SAMPLE_W-1:0]      sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sei_pkg::ACTION_W-1:0]      action,
  output logic [sei_pkg::VALUE_W-1:0]       filtered,
  input  logic                              cfg_we,
  input  logic [sei_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sei_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sei_pkg::*;

  `include "stepper_extremum_indexer_assert.svh"

  localparam logic [COUNT_W-1:0] PRIME_CNT   = COUNT_W'(PRIME_READS);
  localparam bit                 PRIME_SHORT = (PRIME_READS <= 1);
  localparam int                 WIDE_W      = SUM_W + 1;
  localparam logic signed [WIDE_W-1:0] SUM_HI = WIDE_W'(4095);
  localparam logic signed [WIDE_W-1:0] SUM_LO = -WIDE_W'(4096);

  // Configuration registers
  sei_coef_t          coef;
  logic [DELTA_W-1:0] delta;
  logic [COUNT_W-1:0] direction_steps;
  logic [COUNT_W-1:0] offset_steps;

  // Move state
  logic [PHASE_W-1:0]      phase, phase_next;
  logic [COUNT_W-1:0]      step_count, step_count_next;
  logic signed [SUM_W-1:0] direction_sum, direction_sum_next;
  logic [VALUE_W-1:0]      extremum, extremum_next;
  logic [VALUE_W-1:0]      last_value, last_value_next;
  logic [ACTION_W-1:0]     action_next;

  logic                    in_acc;
  logic [VALUE_W-1:0]      value;
  logic [COUNT_W-1:0]      count_inc;
  logic signed [WIDE_W-1:0] sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic [VALUE_W-1:0]      ext_max;
  logic [VALUE_W-1:0]      ext_min;
  logic [VALUE_W:0]        value_plus_delta;
  logic [VALUE_W:0]        ext_min_plus_delta;
  logic                    max_done;
  logic                    min_done;
  logic [PHASE_W-1:0]      search_phase;
  logic [ACTION_W-1:0]     search_action;

  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  sei_fir u_fir (
    .clk      (clk),
    .rst      (rst),
    .shift    (in_acc),
    .sample   (sample),
    .coef     (coef),
    .filtered (value)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.newest     <= COEF_NEWEST_RST;
      coef.middle     <= COEF_MIDDLE_RST;
      coef.oldest     <= COEF_OLDEST_RST;
      delta           <= DELTA_RST;
      direction_steps <= DIRECTION_STEPS_RST;
      offset_steps    <= OFFSET_STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_NEWEST:     coef.newest     <= cfg_data[COEF_W-1:0];
        REG_COEF_MIDDLE:     coef.middle     <= cfg_data[COEF_W-1:0];
        REG_COEF_OLDEST:     coef.oldest     <= cfg_data[COEF_W-1:0];
        REG_DELTA:           delta           <= cfg_data[DELTA_W-1:0];
        REG_DIRECTION_STEPS: direction_steps <= cfg_data[COUNT_W-1:0];
        REG_OFFSET_STEPS:    offset_steps    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared arithmetic for the phase logic
  always_comb begin
    count_inc = (step_count == '1) ? step_count : step_count + 1'b1;
    sum_wide  = WIDE_W'(direction_sum) + $signed({2'b00, last_value})
              - $signed({2'b00, value});
    if (sum_wide > SUM_HI) begin
      sum_sat = SUM_W'(SUM_HI);
    end else if (sum_wide < SUM_LO) begin
      sum_sat = SUM_W'(SUM_LO);
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    ext_max            = (value > extremum) ? value : extremum;
    ext_min            = (value < extremum) ? value : extremum;
    value_plus_delta   = {1'b0, value} + {1'b0, delta};
    ext_min_plus_delta = {1'b0, ext_min} + {1'b0, delta};
    max_done           = value_plus_delta < {1'b0, ext_max};
    min_done           = {1'b0, value} > ext_min_plus_delta;
    search_phase       = (offset_steps == '0) ? PH_IDLE : PH_OFFSET;
    search_action      = (offset_steps == '0) ? ACT_DONE : ACT_STEP;
  end

  // Phase sequencer
  always_comb begin
    phase_next         = phase;
    step_count_next    = step_count;
    direction_sum_next = direction_sum;
    extremum_next      = extremum;
    last_value_next    = last_value;
    action_next        = ACT_IDLE;
    unique case (phase)
      PH_PRIME: begin
        if (count_inc >= PRIME_CNT) begin
          last_value_next    = value;
          step_count_next    = '0;
          direction_sum_next = '0;
          phase_next         = PH_DIR;
          action_next        = ACT_STEP;
        end else begin
          step_count_next = count_inc;
          action_next     = ACT_READ;
        end
      end
      PH_DIR: begin
        direction_sum_next = sum_sat;
        last_value_next    = value;
        step_count_next    = count_inc;
        action_next        = ACT_STEP;
        if (count_inc >= direction_steps && sum_sat != '0) begin
          extremum_next = value;
          phase_next    = sum_sat[SUM_W-1] ? PH_MAX : PH_MIN;
        end
      end
      PH_MAX: begin
        last_value_next = value;
        extremum_next   = ext_max;
        action_next     = ACT_STEP;
        if (max_done) begin
          step_count_next = '0;
          phase_next      = search_phase;
          action_next     = search_action;
        end
      end
      PH_MIN: begin
        last_value_next = value;
        extremum_next   = ext_min;
        action_next     = ACT_STEP;
        if (min_done) begin
          step_count_next = '0;
          phase_next      = search_phase;
          action_next     = search_action;
        end
      end
      PH_OFFSET: begin
        last_value_next = value;
        if (count_inc >= offset_steps) begin
          phase_next      = PH_IDLE;
          step_count_next = '0;
          action_next     = ACT_DONE;
        end else begin
          step_count_next = count_inc;
          action_next     = ACT_STEP;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          direction_sum_next = '0;
          if (PRIME_SHORT) begin
            last_value_next = value;
            step_count_next = '0;
            phase_next      = PH_DIR;
            action_next     = ACT_STEP;
          end else begin
            step_count_next = COUNT_W'(1);
            phase_next      = PH_PRIME;
            action_next     = ACT_READ;
          end
        end
      end
    endcase
  end

  // Advance the move state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      step_count    <= '0;
      direction_sum <= '0;
      extremum      <= '0;
      last_value    <= '0;
    end else if (in_acc) begin
      phase         <= phase_next;
      step_count    <= step_count_next;
      direction_sum <= direction_sum_next;
      extremum      <= extremum_next;
      last_value    <= last_value_next;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action   <= action_next;
      filtered <= value;
    end
  end

  `SEI_ASSERT_NEXT(a_idle_no_start, in_acc && phase == PH_IDLE && !start_req,
                   action == ACT_IDLE, "idle word without start must answer idle")
  `SEI_ASSERT_NEXT(a_no_early_done, in_acc && (phase == PH_PRIME || phase == PH_DIR),
                   action != ACT_DONE, "done reported before a search finished")
  `SEI_ASSERT_NOW(a_done_goes_idle, out_valid && action == ACT_DONE,
                  phase == PH_IDLE, "phase not idle after done")
  `SEI_ASSERT_NOW(a_prime_count, phase == PH_PRIME,
                  step_count != '0 && step_count < PRIME_CNT, "priming count out of range")

endmodule

>>> rtl/sei_fir.sv
module sei_fir (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            shift,
  input  logic [sei_pkg::SAMPLE_W-1:0]    sample,
  input  sei_pkg::sei_coef_t              coef,
  output logic [sei_pkg::VALUE_W-1:0]     filtered
);
  import sei_pkg::*;

  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + 2;

  logic [SAMPLE_W-1:0] tap_newest;
  logic [SAMPLE_W-1:0] tap_middle;
  logic [SAMPLE_W-1:0] tap_oldest;
  logic [PROD_W-1:0]   prod_newest;
  logic [PROD_W-1:0]   prod_middle;
  logic [PROD_W-1:0]   prod_oldest;
  logic [ACC_W-1:0]    acc;

  // Weight the stored taps; the current sample does not take part
  always_comb begin
    prod_newest = PROD_W'(tap_newest) * PROD_W'(coef.newest);
    prod_middle = PROD_W'(tap_middle) * PROD_W'(coef.middle);
    prod_oldest = PROD_W'(tap_oldest) * PROD_W'(coef.oldest);
    acc = ACC_W'(prod_newest) + ACC_W'(prod_middle) + ACC_W'(prod_oldest);
  end

  // Truncate the Q0.8 fraction
  assign filtered = acc[COEF_W +: VALUE_W];

  // Advance the tap line on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_newest <= '0;
      tap_middle <= '0;
      tap_oldest <= '0;
    end else if (shift) begin
      tap_oldest <= tap_middle;
      tap_middle <= tap_newest;
      tap_newest <= sample;
    end
  end

endmodule
